### rtl/planar_yuv420_to_tiled_texture_macros.svh
// planar_yuv420_to_tiled_texture_macros.svh
// assertion macros used by the checker file of the tiled texture block
// no dependencies
`ifndef PLANAR_YUV420_TO_TILED_TEXTURE_MACROS_SVH
`define PLANAR_YUV420_TO_TILED_TEXTURE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PYTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tiled texture check failed");

// next-cycle implication, disabled while reset is low
`define PYTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tiled texture check failed");

`endif

### rtl/yuvtile_pkg.sv
// yuvtile_pkg.sv
// widths, register codes, size limits and the size clamp of the tiled texture block
// no dependencies
`default_nettype none

package yuvtile_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned OFFSET_W = 23;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 4;

  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [OFFSET_W-1:0]  offset_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_LINE_WIDTH = cfg_idx_t'(0);
  localparam cfg_idx_t REG_LINE_COUNT = cfg_idx_t'(1);

  localparam size_t   LINE_WIDTH_RST = size_t'(640);
  localparam size_t   LINE_COUNT_RST = size_t'(480);
  localparam offset_t AREA_RST       = offset_t'(640 * 480);

  // clear the low three bits, floor at 8, clamp to the limit
  function automatic size_t eff_size(input size_t raw, input logic [13:0] max_sz);
    size_t v;
    v = raw & size_t'(12'hFF8);
    if (v < size_t'(8)) v = size_t'(8);
    if ({2'b00, v} > max_sz) v = size_t'(max_sz & ~14'd7);
    if (v < size_t'(8)) v = size_t'(8);
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/yuvtile_if.sv
// yuvtile_if.sv
// valid/ready channel interfaces: source byte in, tiled word out, register writes
// depends on yuvtile_pkg
`default_nettype none

interface yuvtile_in_if import yuvtile_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink   (input valid, input sample_byte, output ready);
endinterface

interface yuvtile_out_if import yuvtile_pkg::*; ();
  logic    valid;
  logic    ready;
  offset_t dest_offset;
  byte_t   dest_byte;
  logic    frame_end;

  modport source (output valid, output dest_offset, output dest_byte, output frame_end,
                  input ready);
  modport sink   (input valid, input dest_offset, input dest_byte, input frame_end,
                  output ready);
endinterface

interface yuvtile_cfg_if import yuvtile_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  size_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/planar_yuv420_to_tiled_texture.sv
// planar 4:2:0 frame bytes to tiled texture byte offsets
// one byte in, one word out
// depends on yuvtile_pkg and the channel interfaces in yuvtile_if.sv
//
// usage
// - sample_i takes the frame bytes in buffer order: Y plane raster, then U, then V
// - result_o gives each byte with its destination offset; frame_end marks the
//   last V byte, after which the counters start the next frame
// - cfg_i writes line_width (index 0) and line_count (index 1); it is always
//   ready, other indexes are ignored; write only while no word is in flight
// - throughput: one word per cycle while result_o.ready stays high, with no bubbles
// - pipeline: the input register, then the result register after the tile
//   multiply and offset add
// - stall: when result_o.ready is low and the result register is full, it holds;
//   the input register still takes one more word, then sample_i.ready drops
// - reset: counters go to the start of the Y plane, 640x480 is loaded,
//   both pipeline stages empty
// - luma area w*h is kept in a register updated on each size write
`default_nettype none

module planar_yuv420_to_tiled_texture import yuvtile_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  yuvtile_cfg_if.sink   cfg_i,
  yuvtile_in_if.sink    sample_i,
  yuvtile_out_if.source result_o
);

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  // configuration and luma area
  size_t   line_width_q, line_count_q;
  offset_t area_q, area_d;
  size_t   w_eff, h_eff;
  logic [2*SIZE_W-1:0] area_prod;
  size_t   mul_a, mul_b;

  // frame position counters
  count_t col_q, col_d, row_q, row_d;
  plane_e plane_q, plane_d;
  logic   last_d;
  size_t  cols, rows;
  size_t  col_inc, row_inc;

  // input register
  logic   s1_valid_q;
  byte_t  s1_byte_q;
  count_t s1_col_q, s1_row_q;
  plane_e s1_plane_q;
  logic   s1_last_q;

  // result register
  logic    s2_valid_q;
  offset_t s2_offset_q;
  byte_t   s2_byte_q;
  logic    s2_last_q;

  logic in_fire, s2_load, cfg_fire;

  assign w_eff = eff_size(line_width_q, 14'(MAX_WIDTH));
  assign h_eff = eff_size(line_count_q, 14'(MAX_HEIGHT));

  // handshakes
  assign cfg_i.ready    = 1'b1;
  assign cfg_fire       = cfg_i.valid;
  assign s2_load        = s1_valid_q && (!s2_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || s2_load;
  assign in_fire        = sample_i.valid && sample_i.ready;

  // new area from the written size and the other, held size
  always_comb begin
    mul_a = w_eff;
    mul_b = h_eff;
    unique case (cfg_i.index)
      REG_LINE_WIDTH: mul_a = eff_size(cfg_i.data, 14'(MAX_WIDTH));
      REG_LINE_COUNT: mul_b = eff_size(cfg_i.data, 14'(MAX_HEIGHT));
      default: ;
    endcase
  end

  assign area_prod = {{SIZE_W{1'b0}}, mul_a} * {{SIZE_W{1'b0}}, mul_b};
  assign area_d    = area_prod[OFFSET_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_count_q <= LINE_COUNT_RST;
      area_q       <= AREA_RST;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_LINE_WIDTH: begin
          line_width_q <= cfg_i.data;
          area_q       <= area_d;
        end
        REG_LINE_COUNT: begin
          line_count_q <= cfg_i.data;
          area_q       <= area_d;
        end
        default: ;
      endcase
    end
  end

  // plane dimensions: chroma is half size in both directions
  always_comb begin
    if (plane_q == PLANE_Y) begin
      cols = w_eff;
      rows = h_eff;
    end else begin
      cols = {1'b0, w_eff[SIZE_W-1:1]};
      rows = {1'b0, h_eff[SIZE_W-1:1]};
    end
  end

  assign col_inc = {1'b0, col_q} + size_t'(1);
  assign row_inc = {1'b0, row_q} + size_t'(1);

  // counter advance; a counter at or past a shrunk limit wraps here
  always_comb begin
    col_d   = col_inc[COUNT_W-1:0];
    row_d   = row_q;
    plane_d = plane_q;
    last_d  = 1'b0;
    if (col_inc >= cols) begin
      col_d = '0;
      if (row_inc >= rows) begin
        row_d = '0;
        unique case (plane_q)
          PLANE_Y: plane_d = PLANE_U;
          PLANE_U: plane_d = PLANE_V;
          default: begin
            plane_d = PLANE_Y;
            last_d  = 1'b1;
          end
        endcase
      end else begin
        row_d = row_inc[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      plane_q    <= PLANE_Y;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q   <= col_d;
        row_q   <= row_d;
        plane_q <= plane_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // offset: tile index times 32 plus the position inside the tile, plus the luma area for chroma.
  // luma and chroma both have w/8 tiles per tile row
  logic [SIZE_W-4:0]     tiles_per_row;
  logic [COUNT_W-3:0]    tile_row;
  logic [2*(SIZE_W-3)-1:0] tile_prod;
  logic [OFFSET_W-6:0]   tile_idx;
  logic [OFFSET_W-6:0]   tile_col;
  offset_t               offset_d;

  assign tiles_per_row = w_eff[SIZE_W-1:3];
  assign tile_row      = s1_row_q[COUNT_W-1:2];
  assign tile_prod     = {{(COUNT_W-2){1'b0}}, tiles_per_row} *
                         {{(SIZE_W-3){1'b0}}, tile_row};

  always_comb begin
    if (s1_plane_q == PLANE_Y) begin
      tile_col = (OFFSET_W-5)'(s1_col_q[COUNT_W-1:3]);
    end else begin
      tile_col = (OFFSET_W-5)'(s1_col_q[COUNT_W-1:2]);
    end
  end

  assign tile_idx = tile_prod[OFFSET_W-6:0] + tile_col;

  always_comb begin
    unique case (s1_plane_q)
      PLANE_Y: offset_d = {tile_idx, s1_row_q[1:0], s1_col_q[2:0]};
      PLANE_U: offset_d = area_q + {tile_idx, s1_row_q[1:0], s1_col_q[1:0], 1'b0};
      // V byte follows its U byte
      default: offset_d = area_q + {tile_idx, s1_row_q[1:0], s1_col_q[1:0], 1'b1};
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= sample_i.sample_byte;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_plane_q <= plane_q;
      s1_last_q  <= last_d;
    end
    if (s2_load) begin
      s2_offset_q <= offset_d;
      s2_byte_q   <= s1_byte_q;
      s2_last_q   <= s1_last_q;
    end
  end

  assign result_o.valid       = s2_valid_q;
  assign result_o.dest_offset = s2_offset_q;
  assign result_o.dest_byte   = s2_byte_q;
  assign result_o.frame_end   = s2_last_q;

endmodule

`default_nettype wire

### rtl/yuvtile_checker.sv
// yuvtile_checker.sv
// port-level checks of the tiled texture block, bound to the top level
// depends on yuvtile_pkg and planar_yuv420_to_tiled_texture_macros.svh
`default_nettype none
`include "planar_yuv420_to_tiled_texture_macros.svh"

module yuvtile_checker import yuvtile_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input offset_t dest_offset_i,
  input byte_t   dest_byte_i,
  input logic    frame_end_i
);

  logic [OFFSET_W+BYTE_W:0] out_word;
  logic [2:0] pending_q, pending_d;
  logic in_fire, out_fire, out_stall;

  assign out_word  = {dest_offset_i, dest_byte_i, frame_end_i};
  assign in_fire   = in_valid_i && in_ready_i;
  assign out_fire  = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // words accepted but not yet delivered
  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) pending_d = pending_q + 3'd1;
    if (!in_fire && out_fire) pending_d = pending_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `PYTT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_word))
  `PYTT_ASSERT_IMP(a_no_extra, clk_i, rst_ni, out_valid_i, pending_q != 3'd0)
  `PYTT_ASSERT_IMP(a_depth, clk_i, rst_ni, 1'b1, pending_q <= 3'd2)
  `PYTT_ASSERT_IMP(a_end_on_v, clk_i, rst_ni, out_valid_i && frame_end_i, dest_offset_i[0])

endmodule

bind planar_yuv420_to_tiled_texture yuvtile_checker u_yuvtile_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .dest_offset_i(result_o.dest_offset),
  .dest_byte_i  (result_o.dest_byte),
  .frame_end_i  (result_o.frame_end)
);

`default_nettype wire
